[sv/hbc_pkg.sv]
// Shared types, constants and helpers for the handshake bus capture block.
`timescale 1ns / 1ps
`default_nettype none

package hbc_pkg;

    // Width of one stored capture: {timestamp, direction, byte}
    localparam int ENTRY_W = 41;

    // Result queue in the back part, ahead of the output
    localparam int Q_DEPTH = 4;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Timestamp divider reset value
    localparam logic [15:0] TICK_DIV_RESET = 16'd16;

    // Reported phase codes
    localparam logic [1:0] CODE_IDLE    = 2'd0;
    localparam logic [1:0] CODE_CONSOLE = 2'd1;
    localparam logic [1:0] CODE_CART    = 2'd2;

    // Bus phase state, one-hot
    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_CONSOLE = 3'b010,
        PH_CART    = 3'b100
    } t_phase;

    // Per-step status handed from the front to the back
    typedef struct packed {
        logic        pop;
        logic [31:0] drop_total;
        logic [9:0]  fill_level;
        logic [1:0]  phase;
    } t_meta;

    // One finished result as held in the result queue
    typedef struct packed {
        logic        read_valid;
        logic [7:0]  read_data;
        logic        read_dir;
        logic [31:0] read_time;
        logic [31:0] drop_total;
        logic [9:0]  fill_level;
        logic [1:0]  phase;
    } t_result;

    // Map the one-hot phase to its external code
    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_IDLE:    code = CODE_IDLE;
            PH_CONSOLE: code = CODE_CONSOLE;
            PH_CART:    code = CODE_CART;
            default:    code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[sv/hbc_if.sv]
// Channel interfaces: sample input, result output and divider write.
`timescale 1ns / 1ps
`default_nettype none

interface hbc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic       line_c0;
    logic       line_c1;
    logic [7:0] data_bus;

    modport source (output valid, output action, output line_c0, output line_c1,
                    output data_bus, input ready);
    modport sink   (input valid, input action, input line_c0, input line_c1,
                    input data_bus, output ready);
endinterface

interface hbc_out_if;
    logic        valid;
    logic        ready;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        read_dir;
    logic [31:0] read_time;
    logic [31:0] drop_total;
    logic [9:0]  fill_level;
    logic [1:0]  phase;

    modport source (output valid, output read_valid, output read_data, output read_dir,
                    output read_time, output drop_total, output fill_level,
                    output phase, input ready);
    modport sink   (input valid, input read_valid, input read_data, input read_dir,
                    input read_time, input drop_total, input fill_level,
                    input phase, output ready);
endinterface

interface hbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] tick_divider;

    modport source (output valid, output tick_divider, input ready);
    modport sink   (input valid, input tick_divider, output ready);
endinterface

`default_nettype wire

[sv/hbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/hbc_front.sv]
// Front part: edge detection, phase tracking, ring pointers, prescaler, RAM access.
`timescale 1ns / 1ps
`default_nettype none

module hbc_front #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    hbc_in_if.sink                           i_in,
    hbc_cfg_if.sink                          i_cfg,
    input  wire logic                        i_room,
    output logic                             o_issue,
    output hbc_pkg::t_meta                   o_meta,
    output logic                             o_wr_en,
    output logic [AW-1:0]                    o_wr_addr,
    output logic [hbc_pkg::ENTRY_W-1:0]      o_wr_data,
    output logic                             o_rd_en,
    output logic [AW-1:0]                    o_rd_addr
);

    localparam int EXT_W = AW + 1;

    hbc_pkg::t_phase r_phase, n_phase;
    logic            r_prev_c0, r_prev_c1;
    logic [AW-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [31:0]     r_drop, n_drop;
    logic [31:0]     r_time;
    logic [15:0]     r_pre;
    logic [15:0]     r_div;
    logic            r_issue;
    hbc_pkg::t_meta  r_meta;

    logic            xfer, pop, cap, cap_dir, full, push, tick;
    logic [EXT_W-1:0] diff;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign i_in.ready  = i_room;
    assign i_cfg.ready = 1'b1;
    assign xfer        = i_in.valid & i_room;

    // step decode: pop first, then line 0 edge, then line 1 edge
    always_comb begin
        n_phase = r_phase;
        cap     = 1'b0;
        cap_dir = 1'b0;
        pop     = i_in.action && (r_rp != r_wp);
        n_rp    = pop ? next_ptr(r_rp) : r_rp;

        if (i_in.line_c0 != r_prev_c0) begin
            if (i_in.line_c0) begin
                if (r_phase == hbc_pkg::PH_IDLE) begin
                    cap     = 1'b1;
                    n_phase = hbc_pkg::PH_CONSOLE;
                end
            end else if (!r_prev_c1) begin
                n_phase = hbc_pkg::PH_IDLE;
            end
        end

        if (i_in.line_c1 != r_prev_c1) begin
            if (i_in.line_c1) begin
                if (n_phase == hbc_pkg::PH_IDLE) begin
                    cap     = 1'b1;
                    cap_dir = 1'b1;
                    n_phase = hbc_pkg::PH_CART;
                end
            end else if (!i_in.line_c0) begin
                n_phase = hbc_pkg::PH_IDLE;
            end
        end

        // one slot always kept empty
        full   = (next_ptr(r_wp) == n_rp);
        push   = cap & ~full;
        n_wp   = push ? next_ptr(r_wp) : r_wp;
        n_drop = r_drop + 32'(cap & full);

        // divider of zero behaves as one
        tick = ({1'b0, r_pre} + 17'd1) >= {1'b0, r_div};

        // fill level after this step
        if (n_wp >= n_rp) begin
            diff = {1'b0, n_wp} - {1'b0, n_rp};
        end else begin
            diff = {1'b0, n_wp} + EXT_W'(DEPTH) - {1'b0, n_rp};
        end
    end

    // divider register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= hbc_pkg::TICK_DIV_RESET;
        end else if (i_cfg.valid) begin
            r_div <= i_cfg.tick_divider;
        end
    end

    // step state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= hbc_pkg::PH_IDLE;
            r_prev_c0 <= 1'b0;
            r_prev_c1 <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_drop    <= '0;
            r_time    <= '0;
            r_pre     <= '0;
            r_issue   <= 1'b0;
        end else begin
            r_issue <= xfer;
            if (xfer) begin
                r_phase   <= n_phase;
                r_prev_c0 <= i_in.line_c0;
                r_prev_c1 <= i_in.line_c1;
                r_wp      <= n_wp;
                r_rp      <= n_rp;
                r_drop    <= n_drop;
                if (tick) begin
                    r_pre  <= '0;
                    r_time <= r_time + 32'd1;
                end else begin
                    r_pre  <= r_pre + 16'd1;
                end
            end
        end
    end

    // status travels alongside the RAM read
    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_meta.pop        <= pop;
            r_meta.drop_total <= n_drop;
            r_meta.fill_level <= 10'(diff);
            r_meta.phase      <= hbc_pkg::phase_code(n_phase);
        end
    end

    assign o_issue   = r_issue;
    assign o_meta    = r_meta;
    assign o_wr_en   = xfer & push;
    assign o_wr_addr = r_wp;
    assign o_wr_data = {r_time, cap_dir, i_in.data_bus};
    assign o_rd_en   = xfer & pop;
    assign o_rd_addr = r_rp;

endmodule

`default_nettype wire

[sv/hbc_back.sv]
// Back part: joins RAM read data with step status and queues finished results.
`timescale 1ns / 1ps
`default_nettype none

module hbc_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_issue,
    input  hbc_pkg::t_meta                   i_meta,
    input  wire logic [hbc_pkg::ENTRY_W-1:0] i_rd_data,
    output logic                             o_room,
    hbc_out_if.source                        o_out
);

    hbc_pkg::t_result                r_q [hbc_pkg::Q_DEPTH];
    logic [hbc_pkg::Q_IDX_W-1:0]     r_head, r_tail;
    logic [hbc_pkg::Q_CNT_W-1:0]     r_count;
    hbc_pkg::t_result                res;
    logic                            deq;

    // assemble result; popped fields read zero when nothing was popped
    always_comb begin
        res.read_valid = i_meta.pop;
        res.read_data  = i_meta.pop ? i_rd_data[7:0]  : 8'd0;
        res.read_dir   = i_meta.pop ? i_rd_data[8]    : 1'b0;
        res.read_time  = i_meta.pop ? i_rd_data[40:9] : 32'd0;
        res.drop_total = i_meta.drop_total;
        res.fill_level = i_meta.fill_level;
        res.phase      = i_meta.phase;
    end

    assign deq    = o_out.valid & o_out.ready;
    // room counts the transfer already in flight
    assign o_room = (r_count + hbc_pkg::Q_CNT_W'(i_issue)) <
                    hbc_pkg::Q_CNT_W'(hbc_pkg::Q_DEPTH);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_q[r_tail] <= res;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_issue) begin
                r_tail <= r_tail + 1'b1;
            end
            if (deq) begin
                r_head <= r_head + 1'b1;
            end
            r_count <= r_count + hbc_pkg::Q_CNT_W'(i_issue) - hbc_pkg::Q_CNT_W'(deq);
        end
    end

    assign o_out.valid      = (r_count != '0);
    assign o_out.read_valid = r_q[r_head].read_valid;
    assign o_out.read_data  = r_q[r_head].read_data;
    assign o_out.read_dir   = r_q[r_head].read_dir;
    assign o_out.read_time  = r_q[r_head].read_time;
    assign o_out.drop_total = r_q[r_head].drop_total;
    assign o_out.fill_level = r_q[r_head].fill_level;
    assign o_out.phase      = r_q[r_head].phase;

endmodule

`default_nettype wire

[sv/handshake_bus_capture.sv]
// Top level of the handshake bus capture block.
// Usage:
//   i_in carries one sample per transfer: action (1 = also pop the oldest
//   capture), the two handshake lines and the eight-bit data bus.
//   o_out returns exactly one result per sample: popped entry (if any), drop
//   count, fill level after the step and the current bus phase.
//   i_cfg writes the timestamp divider (samples per tick); always ready. Write
//   it only while no sample is in flight; the block does not enforce this.
// Throughput: one sample per cycle while the result queue has room; all step
//   state updates on the input transfer's edge, and the capture RAM has one
//   write and one read port, each used at most once per sample.
// Result path: RAM read data and status are registered on the transfer edge,
//   the result queue takes them on the next, and o_out.valid rises once the
//   queue holds the result.
// Receiver stall: results collect in a four-entry queue; input ready drops
//   once the queue plus the result in flight would fill it.
// Reset: synchronous, active low; phase idle, pointers, counters and
//   prescaler cleared, divider back to 16. The capture RAM is not cleared;
//   only written entries are ever popped.
`timescale 1ns / 1ps
`default_nettype none

module handshake_bus_capture #(
    parameter int FIFO_DEPTH = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hbc_in_if.sink     i_in,
    hbc_cfg_if.sink    i_cfg,
    hbc_out_if.source  o_out
);

    localparam int AW = $clog2(FIFO_DEPTH);

    logic                        room;
    logic                        issue;
    hbc_pkg::t_meta              meta;
    logic                        wr_en, rd_en;
    logic [AW-1:0]               wr_addr, rd_addr;
    logic [hbc_pkg::ENTRY_W-1:0] wr_data, rd_data;

    // sample decode and capture control
    hbc_front #(
        .DEPTH (FIFO_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_room    (room),
        .o_issue   (issue),
        .o_meta    (meta),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    // capture ring storage
    hbc_ram #(
        .WIDTH (hbc_pkg::ENTRY_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result assembly and output queue
    hbc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (issue),
        .i_meta    (meta),
        .i_rd_data (rd_data),
        .o_room    (room),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
